// ===== design/glr_pkg.sv =====
// Shared types and constants for the glyph row rasterizer.
// Holds the pixel class struct, the row struct handed between stages and register indexes.
// Depends on nothing.
package glr_pkg;

    localparam int MAX_WIDTH  = 32;
    localparam int MAX_HEIGHT = 64;

    localparam int ROW_W   = 32;
    localparam int X_W     = 5;
    localparam int Y_W     = 6;
    localparam int WCFG_W  = 6;
    localparam int HCFG_W  = 7;
    localparam int COLOR_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHADOW_COLOR = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [WCFG_W-1:0]  RST_GLYPH_WIDTH  = 6'd16;
    localparam logic [HCFG_W-1:0]  RST_GLYPH_HEIGHT = 7'd16;
    localparam logic [COLOR_W-1:0] RST_FG_COLOR     = 8'd245;
    localparam logic [COLOR_W-1:0] RST_SHADOW_COLOR = 8'd35;

    // Class of one pixel as found by a lane.
    typedef struct packed {
        logic ink;
        logic shade;
    } pix_t;

    // One classified row waiting to be emitted.
    typedef struct packed {
        pix_t [MAX_WIDTH-1:0] pix;
        logic [Y_W-1:0]       y;
        logic                 last_row;
    } row_t;

endpackage

// ===== design/glr_lane.sv =====
// One column lane: classifies a pixel as foreground, shadow or transparent.
// Depends on glr_pkg for the pixel class struct.
module glr_lane (
    input  logic          ink,
    input  logic          up_left,
    input  logic          shade_en,
    output glr_pkg::pix_t pix
);
    import glr_pkg::*;

    // Foreground wins; the shadow only shows on a clear pixel below-right of ink.
    always_comb
    begin
        pix.ink   = ink;
        pix.shade = !ink && shade_en && up_left;
    end

endmodule

// ===== design/glr_emit.sv =====
// Row serializer: sends a classified row one pixel per cycle unless stalled.
// Depends on glr_pkg for the row struct and widths.
module glr_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load_valid,
    input  glr_pkg::row_t                 load_row,
    output logic                          load_take,
    input  logic [glr_pkg::X_W-1:0]       x_last,
    input  logic [glr_pkg::COLOR_W-1:0]   fg_color,
    input  logic [glr_pkg::COLOR_W-1:0]   shadow_color,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [glr_pkg::COLOR_W-1:0]   pixel_color,
    output logic                          opaque,
    output logic                          is_shadow,
    output logic [glr_pkg::X_W-1:0]       pixel_x,
    output logic [glr_pkg::Y_W-1:0]       pixel_y,
    output logic                          last_in_row,
    output logic                          last_in_glyph
);
    import glr_pkg::*;

    logic                 busy_reg;
    pix_t [MAX_WIDTH-1:0] pix_reg;
    pix_t [MAX_WIDTH-1:0] pix_next;
    logic [X_W-1:0]       x_reg;
    logic [Y_W-1:0]       y_reg;
    logic                 last_row_reg;
    logic                 last_px;
    logic                 fire;

    assign last_px   = (x_reg == x_last);
    assign fire      = busy_reg && !out_stall;
    assign load_take = load_valid && (!busy_reg || (fire && last_px));

    // The current pixel always sits in slot 0; move the rest down by one.
    always_comb
    begin
        for (int i = 0; i < MAX_WIDTH - 1; i++)
        begin
            pix_next[i] = pix_reg[i+1];
        end
        pix_next[MAX_WIDTH-1] = '0;
    end

    // Control and row registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            x_reg    <= '0;
        end
        else if (load_take)
        begin
            busy_reg <= 1'b1;
            x_reg    <= '0;
        end
        else if (fire)
        begin
            if (last_px)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                x_reg <= x_reg + X_W'(1);
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (load_take)
        begin
            pix_reg      <= load_row.pix;
            y_reg        <= load_row.y;
            last_row_reg <= load_row.last_row;
        end
        else if (fire)
        begin
            pix_reg <= pix_next;
        end
    end

    // Result fields come straight from the held row.
    always_comb
    begin
        out_valid     = busy_reg;
        opaque        = pix_reg[0].ink || pix_reg[0].shade;
        is_shadow     = pix_reg[0].shade;
        pixel_color   = pix_reg[0].ink   ? fg_color :
                        pix_reg[0].shade ? shadow_color : '0;
        pixel_x       = x_reg;
        pixel_y       = y_reg;
        last_in_row   = last_px;
        last_in_glyph = last_px && last_row_reg;
    end

endmodule

// ===== design/glyph_row_rasterizer_with_shadow.sv =====
// Top level of the glyph row rasterizer with drop shadow.
// A row accepted into the holding slot is loaded into the serializer once it is free,
// and the serializer then presents the row's first pixel item.
// Throughput: one pixel item per cycle while out_stall is low, set by the single
// serializer output; the next row is taken while the current one is sent.
// Reset: configuration returns to 16/16/245/35, previous row and row counter clear.
module glyph_row_rasterizer_with_shadow (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [glr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [glr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [glr_pkg::ROW_W-1:0]          row_bits,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [glr_pkg::COLOR_W-1:0]        pixel_color,
    output logic                               opaque,
    output logic                               is_shadow,
    output logic [glr_pkg::X_W-1:0]            pixel_x,
    output logic [glr_pkg::Y_W-1:0]            pixel_y,
    output logic                               last_in_row,
    output logic                               last_in_glyph
);
    import glr_pkg::*;

    logic [WCFG_W-1:0]  glyph_width_reg;
    logic [HCFG_W-1:0]  glyph_height_reg;
    logic [COLOR_W-1:0] fg_color_reg;
    logic [COLOR_W-1:0] shadow_color_reg;

    logic [ROW_W-1:0]   prev_row_reg;
    logic [Y_W-1:0]     row_index_reg;
    logic [Y_W-1:0]     row_index_next;

    logic               hold_valid_reg;
    row_t               hold_row_reg;
    logic               hold_take;

    logic [WCFG_W-1:0]  width_eff;
    logic [HCFG_W-1:0]  height_eff;
    logic [X_W-1:0]     x_last;
    logic               last_row;
    logic               shade_en;
    logic               in_fire;
    pix_t [MAX_WIDTH-1:0] lane_pix;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_width_reg  <= RST_GLYPH_WIDTH;
            glyph_height_reg <= RST_GLYPH_HEIGHT;
            fg_color_reg     <= RST_FG_COLOR;
            shadow_color_reg <= RST_SHADOW_COLOR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_data[WCFG_W-1:0];
                REG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[HCFG_W-1:0];
                REG_FG_COLOR:     fg_color_reg     <= cfg_data[COLOR_W-1:0];
                REG_SHADOW_COLOR: shadow_color_reg <= cfg_data[COLOR_W-1:0];
                default:          ;
            endcase
        end
    end

    // Out-of-range width and height fall back to the nearest legal value.
    always_comb
    begin
        if (glyph_width_reg == '0)
            width_eff = WCFG_W'(1);
        else if (glyph_width_reg > WCFG_W'(MAX_WIDTH))
            width_eff = WCFG_W'(MAX_WIDTH);
        else
            width_eff = glyph_width_reg;

        if (glyph_height_reg == '0)
            height_eff = HCFG_W'(1);
        else if (glyph_height_reg > HCFG_W'(MAX_HEIGHT))
            height_eff = HCFG_W'(MAX_HEIGHT);
        else
            height_eff = glyph_height_reg;
    end

    assign x_last   = X_W'(width_eff - WCFG_W'(1));
    assign last_row = (HCFG_W'(row_index_reg) + HCFG_W'(1)) >= height_eff;
    assign row_index_next = last_row ? '0 : row_index_reg + Y_W'(1);
    assign shade_en = (row_index_reg != '0);

    // One lane per column; column 0 has no upper-left neighbor.
    for (genvar g = 0; g < MAX_WIDTH; g++)
    begin : g_lane
        logic up_left;
        if (g == 0)
        begin : g_first
            assign up_left = 1'b0;
        end
        else
        begin : g_rest
            assign up_left = prev_row_reg[g-1];
        end

        glr_lane u_lane (
            .ink      (row_bits[g]),
            .up_left  (up_left),
            .shade_en (shade_en),
            .pix      (lane_pix[g])
        );
    end

    // A row is taken whenever the holding slot is free or empties this cycle.
    assign in_stall = hold_valid_reg && !hold_take;
    assign in_fire  = in_valid && !in_stall;

    // Row state and holding slot control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_row_reg   <= '0;
            row_index_reg  <= '0;
            hold_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            prev_row_reg   <= row_bits;
            row_index_reg  <= row_index_next;
            hold_valid_reg <= 1'b1;
        end
        else if (hold_take)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    // Classified row waiting for the serializer.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hold_row_reg.pix      <= lane_pix;
            hold_row_reg.y        <= row_index_reg;
            hold_row_reg.last_row <= last_row;
        end
    end

    glr_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_valid    (hold_valid_reg),
        .load_row      (hold_row_reg),
        .load_take     (hold_take),
        .x_last        (x_last),
        .fg_color      (fg_color_reg),
        .shadow_color  (shadow_color_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_color   (pixel_color),
        .opaque        (opaque),
        .is_shadow     (is_shadow),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .last_in_row   (last_in_row),
        .last_in_glyph (last_in_glyph)
    );

endmodule
